// ===== design/mb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mb_pkg
// Shared types, register codes and saturation helper for the escape-time block.
// ----------------------------------------------------------------------------
package mb_pkg;

  localparam int VAL_W = 32;
  localparam int WIDE_W = 66;

  // register indexes on the configuration port
  localparam logic [2:0] REG_LL_RE = 3'd0;
  localparam logic [2:0] REG_LL_IM = 3'd1;
  localparam logic [2:0] REG_UR_RE = 3'd2;
  localparam logic [2:0] REG_UR_IM = 3'd3;
  localparam logic [2:0] REG_WIDTH = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_LIMIT = 3'd6;

  // item handed from the front end to the iteration engine
  typedef struct packed {
    logic oob;
    logic signed [VAL_W-1:0] cr;
    logic signed [VAL_W-1:0] ci;
  } mb_item_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_DIV,
    FR_MUL,
    FR_MAP,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
    lo = -hi - WIDE_W'(1);
    if (v > hi) return 32'h7FFF_FFFF;
    else if (v < lo) return 32'h8000_0000;
    else return v[VAL_W-1:0];
  endfunction

endpackage

// ===== design/mb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mb_queue
// Two-entry FIFO between the coordinate front end and the iteration engine.
// ----------------------------------------------------------------------------
module mb_queue import mb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  mb_item_t push_item,
  output logic     full,
  input  logic     pop,
  output mb_item_t pop_item,
  output logic     empty
);

  mb_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

// ===== design/mb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mb_front
// Bounds check, step division (bit-serial, both axes at once) and mapping of
// the pixel to the point c.
// ----------------------------------------------------------------------------
module mb_front import mb_pkg::*; #(
  parameter int MAX_RES = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [11:0]             pixel_col,
  input  logic [11:0]             pixel_row,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] ll_re,
  input  logic signed [VAL_W-1:0] ll_im,
  input  logic signed [VAL_W-1:0] ur_re,
  input  logic signed [VAL_W-1:0] ur_im,
  input  logic [12:0]             width_px,
  input  logic [12:0]             height_px,
  output logic                    push,
  output mb_item_t                push_item,
  input  logic                    q_full
);

  localparam int DIV_STEPS = 33;

  fr_state_t state;
  fr_state_t state_next;

  logic [12:0] res_w, res_h;
  logic [12:0] divisor [2];
  logic [11:0] pix [2];
  logic [32:0] dvd [2];
  logic [32:0] quo [2];
  logic [12:0] rem [2];
  logic        neg [2];
  logic [5:0]  cnt;
  logic signed [46:0] prod [2];
  mb_item_t    item;
  logic        oob_now;
  logic signed [32:0] diff [2];
  logic signed [33:0] step [2];
  logic [13:0] trial [2];

  assign res_w = ({19'd0, width_px} > 32'(MAX_RES)) ? 13'(MAX_RES) : width_px;
  assign res_h = ({19'd0, height_px} > 32'(MAX_RES)) ? 13'(MAX_RES) : height_px;
  assign oob_now = ({1'b0, pixel_col} >= res_w) || ({1'b0, pixel_row} >= res_h);
  assign diff[0] = 33'(ur_re) - 33'(ll_re);
  assign diff[1] = 33'(ur_im) - 33'(ll_im);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      trial[k] = {rem[k], dvd[k][32]};
      step[k] = neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
    end
  end

  assign busy = (state != FR_IDLE);
  assign push = (state == FR_PUSH) && !q_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) state <= FR_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (start) state_next = oob_now ? FR_PUSH : FR_DIV;
      FR_DIV:  if (cnt == 6'(DIV_STEPS - 1)) state_next = FR_MUL;
      FR_MUL:  state_next = FR_MAP;
      FR_MAP:  state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      FR_IDLE: begin
        cnt <= '0;
        item.oob <= oob_now;
        pix[0] <= pixel_col;
        pix[1] <= pixel_row;
        divisor[0] <= res_w;
        divisor[1] <= res_h;
        for (int k = 0; k < 2; k++) begin
          neg[k] <= diff[k][32];
          dvd[k] <= diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
          rem[k] <= '0;
        end
      end
      FR_DIV: begin
        cnt <= cnt + 6'd1;
        for (int k = 0; k < 2; k++) begin
          dvd[k] <= {dvd[k][31:0], 1'b0};
          if (trial[k] >= {1'b0, divisor[k]}) begin
            rem[k] <= 13'(trial[k] - {1'b0, divisor[k]});
            quo[k] <= {quo[k][31:0], 1'b1};
          end else begin
            rem[k] <= trial[k][12:0];
            quo[k] <= {quo[k][31:0], 1'b0};
          end
        end
      end
      FR_MUL: begin
        for (int k = 0; k < 2; k++) begin
          prod[k] <= step[k] * $signed({1'b0, pix[k]});
        end
      end
      FR_MAP: begin
        item.cr <= sat32(WIDE_W'(48'(ll_re) + 48'(prod[0])));
        item.ci <= sat32(WIDE_W'(48'(ll_im) + 48'(prod[1])));
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/mb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mb_back
// Iteration engine: one z = z*z + c update and escape test per cycle while an item runs.
// ----------------------------------------------------------------------------
module mb_back import mb_pkg::*; #(
  parameter int FRAC_BITS = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  mb_item_t              q_item,
  output logic                  pop,
  input  logic [15:0]           iter_limit,
  output logic                  done,
  output logic [COUNT_BITS-1:0] escape_count,
  output logic                  out_of_bounds
);

  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
  // a threshold beyond the magnitude width can never be crossed
  localparam bit ESC_REACH = (ESC_SHIFT < WIDE_W);
  localparam logic [WIDE_W-1:0] ESC_THRESH = WIDE_W'(1) << ESC_SHIFT;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  bk_state_t state;
  bk_state_t state_next;

  logic signed [VAL_W-1:0] zr, zi, cr, ci;
  logic                    have;
  logic [COUNT_BITS-1:0]   n, n_step, limit;
  logic signed [63:0]      rr, ii, ri;
  logic [WIDE_W-1:0]       mag;
  logic                    esc, fin;
  logic signed [WIDE_W-1:0] sr, si;

  always_comb begin
    if (COUNT_BITS < 16 && {16'd0, iter_limit} > 32'(CMAX)) limit = CMAX;
    else limit = COUNT_BITS'(iter_limit);
  end

  always_comb begin
    rr = zr * zr;
    ii = zi * zi;
    ri = zr * zi;
    mag = WIDE_W'(rr[63:0]) + WIDE_W'(ii[63:0]);
    esc = have && ESC_REACH && (mag > ESC_THRESH);
    n_step = have ? n + COUNT_BITS'(1) : n;
    fin = esc || (n_step >= limit);
    sr = (WIDE_W'(rr - ii) >>> FRAC_BITS) + WIDE_W'(cr);
    si = (WIDE_W'(ri) >>> (FRAC_BITS - 1)) + WIDE_W'(ci);
  end

  assign pop = (state == BK_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty && !q_item.oob) state_next = BK_RUN;
      BK_RUN:  if (fin) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == BK_IDLE && !q_empty && q_item.oob) || (state == BK_RUN && fin);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        cr <= q_item.cr;
        ci <= q_item.ci;
        zr <= '0;
        zi <= '0;
        n <= '0;
        have <= 1'b0;
        escape_count <= '0;
        out_of_bounds <= q_item.oob;
      end
      BK_RUN: begin
        if (esc) begin
          escape_count <= n;
        end else begin
          n <= n_step;
          escape_count <= n_step;
          zr <= sat32(sr);
          zi <= sat32(si);
          have <= 1'b1;
        end
        out_of_bounds <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/mandelbrot_escape_time_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Escape-time evaluator: pixel in, iteration count out, APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pixel_col/pixel_row with start high; the item is taken at an edge
//   where busy is low. One result per item appears on escape_count and
//   out_of_bounds for exactly one cycle with done high; the receiver cannot
//   stall, so results are never held back.
//   The front end (bounds check, bit-serial step divider on both axes,
//   multiply, map; an out-of-range pixel skips straight to the hand-off)
//   stays busy from taking an item until it hands it to a two-entry queue,
//   waiting while the queue is full. It then takes the next pixel while the
//   iteration engine still runs.
//   The engine performs one z = z*z + c update plus escape test per cycle
//   until the point escapes or reaches the limit; it pops a new item only
//   when idle, and an out-of-range pixel is popped and reported without
//   running. Sustained throughput is set by the slower of the two engines.
//   Reset restores the register defaults and empties the queue and both
//   engines. The user must write the registers only while the block is
//   idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top import mb_pkg::*; #(
  parameter int MAX_RES = 4096,
  parameter int FRAC_BITS = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [11:0]           pixel_col,
  input  logic [11:0]           pixel_row,
  output logic                  done,
  output logic [COUNT_BITS-1:0] escape_count,
  output logic                  out_of_bounds,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration registers
  logic signed [VAL_W-1:0] ll_re, ll_im, ur_re, ur_im;
  logic [12:0]             width_px, height_px;
  logic [15:0]             iter_limit;
  logic [2:0]              reg_idx;
  logic                    wr_en;

  // queue between front end and iteration engine
  logic     q_push, q_full, q_pop, q_empty;
  mb_item_t q_in, q_out;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ll_re <= -32'sd536870912;
      ll_im <= -32'sd268435456;
      ur_re <= 32'sd268435456;
      ur_im <= 32'sd268435456;
      width_px <= 13'd400;
      height_px <= 13'd400;
      iter_limit <= 16'd400;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LL_RE:  ll_re <= pwdata;
        REG_LL_IM:  ll_im <= pwdata;
        REG_UR_RE:  ur_re <= pwdata;
        REG_UR_IM:  ur_im <= pwdata;
        REG_WIDTH:  width_px <= pwdata[12:0];
        REG_HEIGHT: height_px <= pwdata[12:0];
        REG_LIMIT:  iter_limit <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_LL_RE:  prdata = ll_re;
      REG_LL_IM:  prdata = ll_im;
      REG_UR_RE:  prdata = ur_re;
      REG_UR_IM:  prdata = ur_im;
      REG_WIDTH:  prdata = {19'd0, width_px};
      REG_HEIGHT: prdata = {19'd0, height_px};
      REG_LIMIT:  prdata = {16'd0, iter_limit};
      default:    prdata = '0;
    endcase
  end

  mb_front #(
    .MAX_RES(MAX_RES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .busy      (busy),
    .ll_re     (ll_re),
    .ll_im     (ll_im),
    .ur_re     (ur_re),
    .ur_im     (ur_im),
    .width_px  (width_px),
    .height_px (height_px),
    .push      (q_push),
    .push_item (q_in),
    .q_full    (q_full)
  );

  mb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  mb_back #(
    .FRAC_BITS (FRAC_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_item       (q_out),
    .pop          (q_pop),
    .iter_limit   (iter_limit),
    .done         (done),
    .escape_count (escape_count),
    .out_of_bounds(out_of_bounds)
  );

endmodule
